FILE: design/sart_pkg.sv
// Shared types and constants for the sorted address range table.
package sart_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Request action codes.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // One stored table entry.
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] size;
    logic [31:0] name;
  } entry_t;

  // Read and write request from the sequencer to the entry memory.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wdata;
  } mem_req_t;

  // One result of a request.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr;
    logic [63:0] offset;
    logic [31:0] size;
    logic [31:0] name;
  } result_t;

endpackage

FILE: design/sorted_address_range_table.sv
// Sorted address range table: a clear, an insert into a full table and action code 3
// finish without a search; an insert at the front is the slowest, as it shifts
// every stored entry. Each result waits in the output register until it is taken.
// Inserts are set by the one-entry-per-cycle shift; a lookup is a binary search that
// then reads the entry it found. One request at a time.
// Reset empties the table at once; no clearing pass is run.
module sorted_address_range_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [63:0] address,
  input  logic [31:0] entry_size,
  input  logic [31:0] entry_name,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] found_address,
  output logic [63:0] found_offset,
  output logic [31:0] found_size,
  output logic [31:0] found_name
);

  sart_pkg::mem_req_t          mreq;
  sart_pkg::entry_t            rdata;
  sart_pkg::result_t           res;
  logic [sart_pkg::CNT_W-1:0]  count;
  logic                        seq_idle;
  logic                        seq_done;
  logic                        take;
  logic                        start;

  assign in_ready = seq_idle;
  assign start    = in_valid && in_ready;
  assign take     = seq_done && (!out_valid || out_ready);

  sart_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  sart_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .address     (address),
    .entry_size  (entry_size),
    .entry_name  (entry_name),
    .idle        (seq_idle),
    .done        (seq_done),
    .take        (take),
    .res         (res),
    .count       (count),
    .mreq        (mreq),
    .rdata       (rdata)
  );

  // Output register frees the sequencer while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status        <= res.status;
      found_address <= res.addr;
      found_offset  <= res.offset;
      found_size    <= res.size;
      found_name    <= res.name;
    end
  end

  // The entry count never passes the table depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= sart_pkg::CNT_W'(sart_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  // A table-full status only comes from a full table.
  assert property (@(posedge clk) disable iff (rst)
    (seq_done && res.status == sart_pkg::ST_FULL) |->
      count == sart_pkg::CNT_W'(sart_pkg::TABLE_DEPTH))
    else $error("full status with room left");

  // An accepted request always keeps the sequencer busy for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("request accepted twice in a row");

  // A delivered status is always a defined code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == sart_pkg::ST_OK || status == sart_pkg::ST_NOT_FOUND ||
                   status == sart_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

FILE: design/sart_mem.sv
// Entry memory with one write port and one registered read port.
module sart_mem (
  input  logic               clk,
  input  sart_pkg::mem_req_t req,
  output sart_pkg::entry_t   rdata
);

  sart_pkg::entry_t mem [sart_pkg::TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_idx];
    end
  end

endmodule

FILE: design/sart_seq.sv
// Sequencer: binary search, entry shifting and lookup over the entry memory.
module sart_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   action,
  input  logic [63:0]                  address,
  input  logic [31:0]                  entry_size,
  input  logic [31:0]                  entry_name,
  output logic                         idle,
  output logic                         done,
  input  logic                         take,
  output sart_pkg::result_t            res,
  output logic [sart_pkg::CNT_W-1:0]   count,
  output sart_pkg::mem_req_t           mreq,
  input  sart_pkg::entry_t             rdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_LOOK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                      state;
  logic [1:0]                  act;
  logic [63:0]                 q_addr;
  logic [31:0]                 q_size;
  logic [31:0]                 q_name;
  logic [sart_pkg::CNT_W-1:0]  lo;
  logic [sart_pkg::CNT_W-1:0]  hi;
  logic [sart_pkg::IDX_W-1:0]  mid;
  logic [sart_pkg::CNT_W-1:0]  j;
  logic                        pend;
  logic [sart_pkg::IDX_W-1:0]  pend_idx;
  logic [sart_pkg::CNT_W:0]    mid_sum;
  logic [sart_pkg::CNT_W-1:0]  lo_dec;
  logic [sart_pkg::CNT_W-1:0]  j_dec;

  assign idle    = (state == S_IDLE);
  assign done    = (state == S_DONE);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign lo_dec  = lo - sart_pkg::CNT_W'(1);
  assign j_dec   = j - sart_pkg::CNT_W'(1);

  // Memory requests issued by the current step.
  always_comb begin
    mreq        = '0;
    mreq.rd_idx = mid_sum[sart_pkg::IDX_W:1];
    unique case (state)
      S_SRCH: begin
        if (lo < hi) begin
          mreq.rd_en  = 1'b1;
          mreq.rd_idx = mid_sum[sart_pkg::IDX_W:1];
        end else if (act == sart_pkg::ACT_LOOKUP && lo != '0) begin
          mreq.rd_en  = 1'b1;
          mreq.rd_idx = lo_dec[sart_pkg::IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        // Read the entry below j while the previous one is written one slot up.
        if (j > lo) begin
          mreq.rd_en  = 1'b1;
          mreq.rd_idx = j_dec[sart_pkg::IDX_W-1:0];
        end
        if (pend) begin
          mreq.wr_en  = 1'b1;
          mreq.wr_idx = pend_idx;
          mreq.wdata  = rdata;
        end
      end
      S_WRITE: begin
        mreq.wr_en      = 1'b1;
        mreq.wr_idx     = lo[sart_pkg::IDX_W-1:0];
        mreq.wdata.addr = q_addr;
        mreq.wdata.size = q_size;
        mreq.wdata.name = q_name;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act        <= action;
            q_addr     <= address;
            q_size     <= entry_size;
            q_name     <= entry_name;
            lo         <= '0;
            hi         <= count;
            res.addr   <= '0;
            res.offset <= '0;
            res.size   <= '0;
            res.name   <= '0;
            priority if (action == sart_pkg::ACT_CLEAR) begin
              count      <= '0;
              res.status <= sart_pkg::ST_OK;
              state      <= S_DONE;
            end else if (action == sart_pkg::ACT_INSERT) begin
              if (count == sart_pkg::CNT_W'(sart_pkg::TABLE_DEPTH)) begin
                res.status <= sart_pkg::ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_SRCH;
              end
            end else if (action == sart_pkg::ACT_LOOKUP) begin
              state <= S_SRCH;
            end else begin
              res.status <= sart_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_sum[sart_pkg::IDX_W:1];
            state <= S_CMP;
          end else if (act == sart_pkg::ACT_INSERT) begin
            j     <= count;
            pend  <= 1'b0;
            state <= S_SHIFT;
          end else if (lo == '0) begin
            res.status <= sart_pkg::ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            state <= S_LOOK;
          end
        end
        S_CMP: begin
          // Upper bound step: keep going right past equal addresses.
          if (rdata.addr <= q_addr) begin
            lo <= {1'b0, mid} + sart_pkg::CNT_W'(1);
          end else begin
            hi <= {1'b0, mid};
          end
          state <= S_SRCH;
        end
        S_SHIFT: begin
          pend     <= (j > lo);
          pend_idx <= j[sart_pkg::IDX_W-1:0];
          if (j > lo) begin
            j <= j_dec;
          end else if (!pend) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          count      <= count + sart_pkg::CNT_W'(1);
          res.status <= sart_pkg::ST_OK;
          state      <= S_DONE;
        end
        S_LOOK: begin
          res.status <= sart_pkg::ST_OK;
          res.addr   <= rdata.addr;
          res.offset <= q_addr - rdata.addr;
          res.size   <= rdata.size;
          res.name   <= rdata.name;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
